// File: hdl/sewrm_pkg.sv
package sewrm_pkg;

  localparam int unsigned ByteAddrW = 13;
  localparam int unsigned WordAddrW = 12;
  localparam int unsigned DataW     = 16;
  localparam int unsigned CfgW      = 4;
  localparam int unsigned StepW     = 4;
  localparam int unsigned PinW      = 3;
  localparam int unsigned PreLen    = 12;
  localparam int unsigned MinAddrBits = 6;

  typedef enum logic [2:0] {
    KIND_IDLE   = 3'd0,
    KIND_PRE    = 3'd1,
    KIND_ADDR   = 3'd2,
    KIND_DATA   = 3'd3,
    KIND_FINISH = 3'd4
  } kind_e;

  // pin bit0 select, bit1 clock, bit2 data out
  localparam logic [PinW-1:0] PIN_LOW   = 3'h0;
  localparam logic [PinW-1:0] PIN_SEL   = 3'h1;
  localparam logic [PinW-1:0] PIN_CLK   = 3'h3;

  typedef logic [PinW-1:0] pre_seq_t [PreLen];
  localparam pre_seq_t PRE_SEQ = '{
    3'h0, 3'h1, 3'h3, 3'h1, 3'h5, 3'h7, 3'h5, 3'h7, 3'h5, 3'h1, 3'h3, 3'h1
  };

  typedef struct packed {
    logic                 start_req;
    logic [ByteAddrW-1:0] byte_address;
    logic                 serial_data_in;
  } beat_in_t;

  typedef struct packed {
    logic [PinW-1:0]  pins;
    logic             busy;
    logic             done;
    logic [DataW-1:0] word;
  } beat_out_t;

endpackage

// File: hdl/serial_eeprom_word_read_master.sv
// Word-read master for a three-wire serial EEPROM, one pin phase per beat.
// Input channel (in_valid_i/in_ready_o): one beat per tick carrying the start
// request, the byte address and the sampled memory data-out pin level.
// Output channel (out_valid_o/out_ready_i): exactly one beat per input beat
// with the pin levels to drive, busy, done and the assembled word.
// A start seen while idle latches the word address and the clamped address
// length, then steps through preamble, address bits and 16 data bits; the
// read word shows with done on the final all-low phase.
// A result beat is registered and presented in the cycle after its input
// beat is accepted. Throughput: one beat per cycle unless the output stalls,
// set by the single output register between the sequencer and output channel.
// A stalled receiver holds the output register; a new input beat is taken in
// the same cycle the held one leaves, so no bubble appears.
// address_bits is written through cfg_we_i/cfg_wdata_i and takes effect at
// the next start. Reset: sequencer idle, address_bits 6, no output beat.
module serial_eeprom_word_read_master #(
  parameter int MAX_ADDRESS_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sewrm_pkg::CfgW-1:0]         cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               start_req_i,
  input  logic [sewrm_pkg::ByteAddrW-1:0]    byte_address_i,
  input  logic                               serial_data_in_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               chip_select_o,
  output logic                               serial_clock_o,
  output logic                               serial_data_out_o,
  output logic                               busy_res_o,
  output logic                               done_res_o,
  output logic [sewrm_pkg::DataW-1:0]        read_word_o
);

  logic [sewrm_pkg::CfgW-1:0] address_bits_q;
  logic                       out_valid_q;
  logic                       accept;
  sewrm_pkg::beat_in_t        beat_in;
  sewrm_pkg::beat_out_t       beat_res, res_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign beat_in.start_req      = start_req_i;
  assign beat_in.byte_address   = byte_address_i;
  assign beat_in.serial_data_in = serial_data_in_i;

  sewrm_seq #(
    .MAX_ADDRESS_BITS (MAX_ADDRESS_BITS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (accept),
    .address_bits_i (address_bits_q),
    .beat_i         (beat_in),
    .beat_o         (beat_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      address_bits_q <= sewrm_pkg::CfgW'(sewrm_pkg::MinAddrBits);
    end else if (cfg_we_i) begin
      address_bits_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= beat_res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign chip_select_o     = res_q.pins[0];
  assign serial_clock_o    = res_q.pins[1];
  assign serial_data_out_o = res_q.pins[2];
  assign busy_res_o        = res_q.busy;
  assign done_res_o        = res_q.done;
  assign read_word_o       = res_q.word;

endmodule

// File: hdl/sewrm_seq.sv
module sewrm_seq #(
  parameter int MAX_ADDRESS_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  logic [sewrm_pkg::CfgW-1:0]     address_bits_i,
  input  sewrm_pkg::beat_in_t            beat_i,
  output sewrm_pkg::beat_out_t           beat_o
);

  localparam int LenW = $clog2(MAX_ADDRESS_BITS + 1);

  sewrm_pkg::kind_e                     kind_q, kind_d, kind_eff;
  logic [sewrm_pkg::StepW-1:0]          step_q, step_d, step_eff;
  logic [1:0]                           sub_q, sub_d, sub_eff;
  logic [sewrm_pkg::WordAddrW-1:0]      wa_q, wa_d, wa_eff;
  logic [sewrm_pkg::DataW-1:0]          shift_q, shift_d, shift_eff;
  logic [LenW-1:0]                      len_q, len_d, len_eff, len_sat;
  logic [4:0]                           cfg_ext;
  logic [4:0]                           idx_w;
  logic [3:0]                           pos_w;
  logic                                 addr_bit;

  // clamp requested address length
  always_comb begin
    cfg_ext = 5'(address_bits_i);
    if (cfg_ext < 5'(sewrm_pkg::MinAddrBits)) begin
      len_sat = LenW'(sewrm_pkg::MinAddrBits);
    end else if (cfg_ext > 5'(MAX_ADDRESS_BITS)) begin
      len_sat = LenW'(MAX_ADDRESS_BITS);
    end else begin
      len_sat = LenW'(cfg_ext);
    end
  end

  // state seen by this beat, after a possible start
  always_comb begin
    kind_eff  = kind_q;
    step_eff  = step_q;
    sub_eff   = sub_q;
    wa_eff    = wa_q;
    shift_eff = shift_q;
    len_eff   = len_q;
    if (kind_q == sewrm_pkg::KIND_IDLE && beat_i.start_req) begin
      kind_eff  = sewrm_pkg::KIND_PRE;
      step_eff  = '0;
      sub_eff   = '0;
      wa_eff    = beat_i.byte_address[sewrm_pkg::ByteAddrW-1:1];
      shift_eff = '0;
      len_eff   = len_sat;
    end
  end

  assign idx_w    = 5'(len_eff) - 5'd1 - 5'(step_eff);
  assign addr_bit = (idx_w < 5'(sewrm_pkg::WordAddrW)) ? wa_eff[idx_w[3:0]] : 1'b0;
  assign pos_w    = {step_eff[3], ~step_eff[2:0]};

  // next state
  always_comb begin
    kind_d  = kind_eff;
    step_d  = step_eff;
    sub_d   = sub_eff;
    wa_d    = wa_eff;
    shift_d = shift_eff;
    len_d   = len_eff;
    case (kind_eff)
      sewrm_pkg::KIND_PRE: begin
        step_d = step_eff + sewrm_pkg::StepW'(1);
        if (step_eff == sewrm_pkg::StepW'(sewrm_pkg::PreLen - 1)) begin
          kind_d = sewrm_pkg::KIND_ADDR;
          step_d = '0;
          sub_d  = '0;
        end
      end
      sewrm_pkg::KIND_ADDR: begin
        sub_d = sub_eff + 2'd1;
        if (sub_eff == 2'd2) begin
          sub_d  = '0;
          step_d = step_eff + sewrm_pkg::StepW'(1);
          if (5'(step_eff) + 5'd1 >= 5'(len_eff)) begin
            kind_d = sewrm_pkg::KIND_DATA;
            step_d = '0;
          end
        end
      end
      sewrm_pkg::KIND_DATA: begin
        if (sub_eff == 2'd0) begin
          shift_d = shift_eff | (sewrm_pkg::DataW'(beat_i.serial_data_in) << pos_w);
          sub_d   = 2'd1;
        end else begin
          sub_d  = '0;
          step_d = step_eff + sewrm_pkg::StepW'(1);
          if (step_eff == '1) begin
            kind_d = sewrm_pkg::KIND_FINISH;
            step_d = '0;
          end
        end
      end
      sewrm_pkg::KIND_FINISH: begin
        kind_d = sewrm_pkg::KIND_IDLE;
        step_d = '0;
        sub_d  = '0;
      end
      default: begin
        kind_d = sewrm_pkg::KIND_IDLE;
      end
    endcase
  end

  // beat outputs
  always_comb begin
    beat_o = '0;
    case (kind_eff)
      sewrm_pkg::KIND_PRE: begin
        beat_o.busy = 1'b1;
        beat_o.pins = (step_eff < sewrm_pkg::StepW'(sewrm_pkg::PreLen))
                      ? sewrm_pkg::PRE_SEQ[step_eff] : sewrm_pkg::PIN_LOW;
      end
      sewrm_pkg::KIND_ADDR: begin
        beat_o.busy = 1'b1;
        beat_o.pins = {addr_bit, (sub_eff == 2'd1) ? sewrm_pkg::PIN_CLK[1:0]
                                                   : sewrm_pkg::PIN_SEL[1:0]};
      end
      sewrm_pkg::KIND_DATA: begin
        beat_o.busy = 1'b1;
        beat_o.pins = (sub_eff == 2'd0) ? sewrm_pkg::PIN_CLK : sewrm_pkg::PIN_SEL;
      end
      sewrm_pkg::KIND_FINISH: begin
        beat_o.busy = 1'b1;
        beat_o.done = 1'b1;
        beat_o.word = shift_eff;
      end
      default: begin
        beat_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= sewrm_pkg::KIND_IDLE;
      step_q  <= '0;
      sub_q   <= '0;
      wa_q    <= '0;
      shift_q <= '0;
      len_q   <= LenW'(sewrm_pkg::MinAddrBits);
    end else if (adv_i) begin
      kind_q  <= kind_d;
      step_q  <= step_d;
      sub_q   <= sub_d;
      wa_q    <= wa_d;
      shift_q <= shift_d;
      len_q   <= len_d;
    end
  end

endmodule

// File: hdl/sewrm_chk.sv
module sewrm_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic                               chip_select_o,
  input logic                               serial_clock_o,
  input logic                               serial_data_out_o,
  input logic                               busy_res_o,
  input logic                               done_res_o,
  input logic [sewrm_pkg::DataW-1:0]        read_word_o
);

  // held beat stays put while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_word_o)
      && $stable(done_res_o) && $stable(busy_res_o) && $stable(chip_select_o))
    else $error("output beat changed while stalled");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> !chip_select_o && !serial_clock_o
      && !serial_data_out_o && !done_res_o && read_word_o == '0)
    else $error("idle beat drives pins or data");

  a_done_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> busy_res_o && !chip_select_o && !serial_clock_o
      && !serial_data_out_o)
    else $error("done beat not an all-low busy phase");

  a_clk_selected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && serial_clock_o |-> chip_select_o && busy_res_o)
    else $error("serial clock without chip select");

endmodule

bind serial_eeprom_word_read_master sewrm_chk u_sewrm_chk (.*);

// File: bench/tb_serial_eeprom_word_read_master.sv
module tb_serial_eeprom_word_read_master;

  localparam int unsigned MaxAddrBits = 12;
  localparam int unsigned SegTicks    = 120;
  localparam int unsigned CycleLimit  = 200000;
  // preamble pin states, first phase in the lowest slice
  localparam logic [35:0] PREAMBLE = {
    3'h1, 3'h3, 3'h1, 3'h5, 3'h7, 3'h5, 3'h7, 3'h5, 3'h1, 3'h3, 3'h1, 3'h0
  };

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                            cfg_we    = 1'b0;
  logic [sewrm_pkg::CfgW-1:0]      cfg_wdata = '0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready_o;
  logic                            start_req = 1'b0;
  logic [sewrm_pkg::ByteAddrW-1:0] byte_address = '0;
  logic                            serial_data_in = 1'b0;
  logic                            out_valid_o;
  logic                            out_ready = 1'b0;
  logic                            chip_select_o;
  logic                            serial_clock_o;
  logic                            serial_data_out_o;
  logic                            busy_res_o;
  logic                            done_res_o;
  logic [sewrm_pkg::DataW-1:0]     read_word_o;

  sewrm_pkg::beat_in_t  pending_ticks[$];
  sewrm_pkg::beat_out_t expected_beats[$];
  int unsigned queued_count  = 0;
  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 64;
  int unsigned errors        = 0;
  int unsigned cycle_count   = 0;
  logic        in_fire  = 1'b0;
  logic        out_fire = 1'b0;

  // sequencer shadow state
  sewrm_pkg::kind_e           seq_kind  = sewrm_pkg::KIND_IDLE;
  int unsigned                seq_step  = 0;
  int unsigned                seq_sub   = 0;
  int unsigned                seq_alen  = 6;
  logic [11:0]                seq_waddr = '0;
  logic [15:0]                seq_shift = '0;
  logic [2:0]                 seq_pins  = '0;
  logic [sewrm_pkg::CfgW-1:0] seq_cfg   = 4'd6;

  serial_eeprom_word_read_master #(
    .MAX_ADDRESS_BITS(MaxAddrBits)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready_o),
    .start_req_i       (start_req),
    .byte_address_i    (byte_address),
    .serial_data_in_i  (serial_data_in),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready),
    .chip_select_o     (chip_select_o),
    .serial_clock_o    (serial_clock_o),
    .serial_data_out_o (serial_data_out_o),
    .busy_res_o        (busy_res_o),
    .done_res_o        (done_res_o),
    .read_word_o       (read_word_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned clamp_addr_bits(logic [sewrm_pkg::CfgW-1:0] v);
    if (v < sewrm_pkg::MinAddrBits) return sewrm_pkg::MinAddrBits;
    if (v > MaxAddrBits) return MaxAddrBits;
    return 32'(v);
  endfunction

  function automatic sewrm_pkg::beat_out_t pin_sequence_tick(sewrm_pkg::beat_in_t t);
    sewrm_pkg::beat_out_t r;
    int unsigned          pos;
    r = '0;
    if (seq_kind == sewrm_pkg::KIND_IDLE) begin
      seq_pins = 3'h0;
      if (t.start_req) begin
        seq_alen  = clamp_addr_bits(seq_cfg);
        seq_waddr = t.byte_address[sewrm_pkg::ByteAddrW-1:1];
        seq_shift = '0;
        seq_step  = 0;
        seq_sub   = 0;
        seq_kind  = sewrm_pkg::KIND_PRE;
      end
    end
    case (seq_kind)
      sewrm_pkg::KIND_PRE: begin
        r.busy   = 1'b1;
        seq_pins = PREAMBLE[seq_step*3 +: 3];
        seq_step++;
        if (seq_step >= 12) begin
          seq_kind = sewrm_pkg::KIND_ADDR;
          seq_step = 0;
          seq_sub  = 0;
        end
      end
      sewrm_pkg::KIND_ADDR: begin
        r.busy   = 1'b1;
        seq_pins = {seq_waddr[seq_alen - 1 - seq_step], (seq_sub == 1) ? 2'b11 : 2'b01};
        seq_sub++;
        if (seq_sub >= 3) begin
          seq_sub = 0;
          seq_step++;
          if (seq_step >= seq_alen) begin
            seq_kind = sewrm_pkg::KIND_DATA;
            seq_step = 0;
          end
        end
      end
      sewrm_pkg::KIND_DATA: begin
        r.busy = 1'b1;
        if (seq_sub == 0) begin
          pos            = (23 - seq_step) % 16;
          seq_pins       = 3'h3;
          seq_shift[pos] = seq_shift[pos] | t.serial_data_in;
          seq_sub        = 1;
        end else begin
          seq_pins = 3'h1;
          seq_sub  = 0;
          seq_step++;
          if (seq_step >= 16) begin
            seq_kind = sewrm_pkg::KIND_FINISH;
            seq_step = 0;
          end
        end
      end
      sewrm_pkg::KIND_FINISH: begin
        r.busy   = 1'b1;
        r.done   = 1'b1;
        r.word   = seq_shift;
        seq_pins = 3'h0;
        seq_kind = sewrm_pkg::KIND_IDLE;
        seq_step = 0;
        seq_sub  = 0;
      end
      default: begin
        seq_pins = 3'h0;
      end
    endcase
    r.pins = seq_pins;
    return r;
  endfunction

  always @(negedge clk_i) begin : driver
    sewrm_pkg::beat_in_t cur;
    if (rst_n) begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!in_valid || in_fire) begin
        if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur = pending_ticks.pop_front();
          in_valid       <= 1'b1;
          start_req      <= cur.start_req;
          byte_address   <= cur.byte_address;
          serial_data_in <= cur.serial_data_in;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    sewrm_pkg::beat_out_t want;
    sewrm_pkg::beat_in_t  seen;
    in_fire  = in_valid && in_ready_o;
    out_fire = out_valid_o && out_ready;
    if (rst_n) begin
      if (cfg_we) seq_cfg = cfg_wdata;
      if (out_fire) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with no expected beat");
          errors++;
        end else begin
          want = expected_beats.pop_front();
          if (chip_select_o !== want.pins[0]) begin
            $error("chip_select expected %0d actual %0d", want.pins[0], chip_select_o);
            errors++;
          end
          if (serial_clock_o !== want.pins[1]) begin
            $error("serial_clock expected %0d actual %0d", want.pins[1], serial_clock_o);
            errors++;
          end
          if (serial_data_out_o !== want.pins[2]) begin
            $error("serial_data_out expected %0d actual %0d", want.pins[2],
                   serial_data_out_o);
            errors++;
          end
          if (busy_res_o !== want.busy) begin
            $error("busy_res expected %0d actual %0d", want.busy, busy_res_o);
            errors++;
          end
          if (done_res_o !== want.done) begin
            $error("done_res expected %0d actual %0d", want.done, done_res_o);
            errors++;
          end
          if (read_word_o !== want.word) begin
            $error("read_word expected %h actual %h", want.word, read_word_o);
            errors++;
          end
        end
      end
      if (in_fire) begin
        seen = '{start_req, byte_address, serial_data_in};
        expected_beats.push_back(pin_sequence_tick(seen));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic sewrm_pkg::beat_in_t rand_tick(logic start);
    sewrm_pkg::beat_in_t t;
    int unsigned         pick;
    pick             = $urandom_range(0, 9);
    t.start_req      = start;
    t.byte_address   = (pick == 0) ? '0 : (pick == 1) ? '1
                       : sewrm_pkg::ByteAddrW'($urandom_range(0, 8191));
    t.serial_data_in = 1'($urandom_range(0, 1));
    return t;
  endfunction

  task automatic queue_tick(sewrm_pkg::beat_in_t t);
    pending_ticks.push_back(t);
    queued_count++;
  endtask

  // let any read in flight run out so the next start lands on an idle tick
  task automatic queue_settle();
    repeat (45 + 3 * MaxAddrBits) queue_tick(rand_tick(1'b0));
  endtask

  task automatic queue_read();
    int unsigned len;
    len = 45 + 3 * clamp_addr_bits(seq_cfg);
    queue_tick(rand_tick(1'b1));
    repeat (len - 2) queue_tick(rand_tick($urandom_range(0, 7) == 0));
    queue_tick(rand_tick(1'($urandom_range(0, 1))));
    repeat ($urandom_range(0, 4)) queue_tick(rand_tick(1'b0));
  endtask

  task automatic queue_traffic(int unsigned count);
    int unsigned stop;
    stop = queued_count + count;
    while (queued_count < stop) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(3, 20)) queue_tick(rand_tick($urandom_range(0, 2) == 0));
        queue_settle();
      end else begin
        queue_read();
      end
    end
  endtask

  // checked at the rising edge, where the driven inputs have settled
  task automatic drain();
    @(posedge clk_i);
    while (!(pending_ticks.size() == 0 && !in_valid && expected_beats.size() == 0))
      @(posedge clk_i);
  endtask

  task automatic write_address_bits(logic [sewrm_pkg::CfgW-1:0] v);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  logic [sewrm_pkg::CfgW-1:0] cfg_plan [6] = '{4'd12, 4'd0, 4'd15, 4'd9, 4'd5, 4'd13};

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    write_address_bits(4'd6);
    queue_tick('{1'b0, 13'h1fff, 1'b1});
    queue_tick('{1'b0, 13'h0000, 1'b0});
    queue_tick('{1'b1, 13'h1fff, 1'b0});
    // start held high while the read runs
    for (int i = 0; i < 22; i++) begin
      queue_tick('{1'b1, (i % 2 == 0) ? 13'h0000 : 13'h1fff, i[0]});
    end
    queue_settle();

    for (int seg = 0; seg < 6; seg++) begin
      drain();
      write_address_bits(cfg_plan[seg]);
      send_idle_pct = (seg < 2) ? 37 : (seg < 4) ? 64 : 0;
      recv_idle_pct = (seg < 2) ? 64 : (seg < 4) ? 37 : 0;
      queue_traffic(SegTicks / 2);
      // sender holds off until all results are back
      drain();
      queue_traffic(SegTicks / 2);
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/sewrm_pkg.sv
hdl/sewrm_seq.sv
hdl/serial_eeprom_word_read_master.sv
hdl/sewrm_chk.sv
bench/tb_serial_eeprom_word_read_master.sv
